[hw/rtl/poat_pkg.sv]
package poat_pkg;

    localparam int POINTS     = 4096;
    localparam int OBJECTS    = 1024;
    localparam int CATEGORIES = 64;

    localparam int POINT_W = $clog2(POINTS);
    localparam int OBJ_W   = $clog2(OBJECTS);
    localparam int CAT_W   = $clog2(CATEGORIES);
    localparam int CNT_W   = $clog2(OBJECTS + 1);

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_FINCAT = 3'd1;
    localparam logic [2:0] CMD_ASSIGN = 3'd2;
    localparam logic [2:0] CMD_FINAL  = 3'd3;
    localparam logic [2:0] CMD_QPOINT = 3'd4;
    localparam logic [2:0] CMD_QCAT   = 3'd5;
    localparam logic [2:0] CMD_RES_A  = 3'd6;
    localparam logic [2:0] CMD_RES_B  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_START = 1'b0;
    localparam logic REG_MIN   = 1'b1;

    localparam logic [9:0]  CNT_MAX  = 10'd1023;
    localparam logic [12:0] SIZE_MAX = 13'd8191;

    typedef struct packed {
        logic [2:0]  command;
        logic [12:0] object_size;
        logic [15:0] object_cohesion;
        logic [11:0] point_index;
        logic [9:0]  object_id;
        logic [5:0]  category_id;
    } item_t;

    typedef struct packed {
        logic [9:0]  new_object_id;
        logic        accepted;
        logic [20:0] final_id;
        logic [5:0]  category_out;
        logic [9:0]  cat_object_count;
        logic [12:0] cat_point_sum;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MAP,
        S_ASSIGN,
        S_QPOINT,
        S_QCAT,
        S_FIN_RD,
        S_FIN_TL,
        S_FIN_WR,
        S_RESP
    } state_t;

endpackage

[hw/rtl/point_object_assignment_table.sv]
// Point/object assignment table. Every command is one word in and one result word out.
// After reset the block clears its point map (POINTS entries) and category tallies, one
// entry a cycle, and holds item_stall high meanwhile; configuration writes are taken at
// any time. Add and finish category go from decode straight to the result stage; query
// category reads the tally memories first, and an in-range assign or a query point reads
// the point map and then the object tables, through registered reads. Finalize walks the
// object table one entry at a time: a read, a threshold check and, for an entry that gets
// a final id, a category tally read-modify-write. A new word is taken while the previous
// result still waits at the output.
module point_object_assignment_table
    import poat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    // memories
    logic [9:0]  point_mem [POINTS];
    logic [12:0] size_mem  [OBJECTS];
    logic [15:0] dens_mem  [OBJECTS];
    logic [5:0]  cat_mem   [OBJECTS];
    logic [20:0] fid_mem   [OBJECTS];
    logic [9:0]  tcnt_mem  [CATEGORIES];
    logic [12:0] tsum_mem  [CATEGORIES];

    logic               map_we;
    logic [POINT_W-1:0] map_waddr, map_raddr;
    logic [9:0]         map_wdata, map_rdata;

    logic             size_we;
    logic [OBJ_W-1:0] size_waddr, size_raddr_a, size_raddr_b;
    logic [12:0]      size_wdata, size_rdata_a, size_rdata_b;

    logic             obj_we;
    logic [OBJ_W-1:0] obj_waddr;
    logic [OBJ_W-1:0] dens_raddr_a, dens_raddr_b, cat_raddr, fid_raddr;
    logic [15:0]      dens_rdata_a, dens_rdata_b;
    logic [5:0]       cat_rdata;
    logic [20:0]      fid_rdata;

    logic             fid_we;
    logic [OBJ_W-1:0] fid_waddr;
    logic [20:0]      fid_wdata;

    logic             tally_we;
    logic [CAT_W-1:0] tally_waddr, tally_raddr;
    logic [9:0]       tcnt_wdata, tcnt_rdata;
    logic [12:0]      tsum_wdata, tsum_rdata;

    // control registers
    state_t             state_reg, state_next;
    item_t              item_reg;
    result_t            res_reg, res_next;
    result_t            result_reg;
    logic               result_valid_reg, result_valid_next;
    logic [19:0]        start_reg;
    logic [12:0]        min_reg;
    logic [CNT_W-1:0]   obj_count_reg, obj_count_next;
    logic [5:0]         cur_cat_reg, cur_cat_next;
    logic [POINT_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]   walk_reg, walk_next;
    logic [20:0]        next_id_reg, next_id_next;
    logic [9:0]         old_reg, old_next;
    logic [12:0]        fsize_reg, fsize_next;

    logic        item_take;
    logic        out_free;
    logic [13:0] sum_wide;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign sum_wide     = {1'b0, tsum_rdata} + {1'b0, fsize_reg};

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            point_mem[map_waddr] <= map_wdata;
        end
        map_rdata <= point_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rdata_a <= size_mem[size_raddr_a];
        size_rdata_b <= size_mem[size_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (obj_we)
        begin
            dens_mem[obj_waddr] <= item_reg.object_cohesion;
            cat_mem[obj_waddr]  <= cur_cat_reg;
        end
        dens_rdata_a <= dens_mem[dens_raddr_a];
        dens_rdata_b <= dens_mem[dens_raddr_b];
        cat_rdata    <= cat_mem[cat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fid_we)
        begin
            fid_mem[fid_waddr] <= fid_wdata;
        end
        fid_rdata <= fid_mem[fid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tally_we)
        begin
            tcnt_mem[tally_waddr] <= tcnt_wdata;
            tsum_mem[tally_waddr] <= tsum_wdata;
        end
        tcnt_rdata <= tcnt_mem[tally_raddr];
        tsum_rdata <= tsum_mem[tally_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == POINT_W'(POINTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_take)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (item_reg.command)
                    CMD_ASSIGN:
                    begin
                        if (item_reg.object_id == 10'd0
                            || CNT_W'(item_reg.object_id) >= obj_count_reg)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_MAP;
                        end
                    end
                    CMD_QPOINT: state_next = S_MAP;
                    CMD_QCAT:   state_next = S_QCAT;
                    CMD_FINAL:  state_next = S_FIN_RD;
                    default:    state_next = S_RESP;
                endcase
            end
            S_MAP:
            begin
                if (item_reg.command == CMD_ASSIGN)
                begin
                    state_next = S_ASSIGN;
                end
                else
                begin
                    state_next = S_QPOINT;
                end
            end
            S_ASSIGN: state_next = S_RESP;
            S_QPOINT: state_next = S_RESP;
            S_QCAT:   state_next = S_RESP;
            S_FIN_RD:
            begin
                if (walk_reg < obj_count_reg)
                begin
                    state_next = S_FIN_TL;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_FIN_TL:
            begin
                if (size_rdata_a < min_reg)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    state_next = S_FIN_WR;
                end
            end
            S_FIN_WR: state_next = S_FIN_RD;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        map_we       = 1'b0;
        map_waddr    = item_reg.point_index[POINT_W-1:0];
        map_wdata    = item_reg.object_id;
        map_raddr    = item_reg.point_index[POINT_W-1:0];
        size_we      = 1'b0;
        size_waddr   = obj_count_reg[OBJ_W-1:0];
        size_wdata   = item_reg.object_size;
        size_raddr_a = map_rdata[OBJ_W-1:0];
        size_raddr_b = item_reg.object_id[OBJ_W-1:0];
        obj_we       = 1'b0;
        obj_waddr    = obj_count_reg[OBJ_W-1:0];
        dens_raddr_a = map_rdata[OBJ_W-1:0];
        dens_raddr_b = item_reg.object_id[OBJ_W-1:0];
        cat_raddr    = map_rdata[OBJ_W-1:0];
        fid_raddr    = map_rdata[OBJ_W-1:0];
        fid_we       = 1'b0;
        fid_waddr    = obj_count_reg[OBJ_W-1:0];
        fid_wdata    = 21'd0;
        tally_we     = 1'b0;
        tally_waddr  = clr_reg[CAT_W-1:0];
        tally_raddr  = item_reg.category_id[CAT_W-1:0];
        tcnt_wdata   = 10'd0;
        tsum_wdata   = 13'd0;

        res_next          = res_reg;
        result_valid_next = result_valid_reg && result_stall;
        obj_count_next    = obj_count_reg;
        cur_cat_next      = cur_cat_reg;
        clr_next          = clr_reg;
        walk_next         = walk_reg;
        next_id_next      = next_id_reg;
        old_next          = old_reg;
        fsize_next        = fsize_reg;

        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = 10'd0;
                tally_we  = (32'(clr_reg) < CATEGORIES);
                clr_next  = clr_reg + POINT_W'(1);
            end
            S_DECODE:
            begin
                res_next = '0;
                case (item_reg.command)
                    CMD_ADD:
                    begin
                        if (obj_count_reg == CNT_W'(OBJECTS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            size_we = 1'b1;
                            obj_we  = 1'b1;
                            fid_we  = 1'b1;
                            res_next.new_object_id = 10'(obj_count_reg);
                            obj_count_next = obj_count_reg + CNT_W'(1);
                        end
                    end
                    CMD_FINCAT:
                    begin
                        if (32'(cur_cat_reg) + 1 < CATEGORIES && cur_cat_reg < 6'd63)
                        begin
                            cur_cat_next = cur_cat_reg + 6'd1;
                        end
                    end
                    CMD_ASSIGN:
                    begin
                        if (item_reg.object_id == 10'd0
                            || CNT_W'(item_reg.object_id) >= obj_count_reg)
                        begin
                            res_next.status = ST_RANGE;
                        end
                    end
                    CMD_FINAL:
                    begin
                        walk_next    = CNT_W'(1);
                        next_id_next = {1'b0, start_reg};
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MAP:
            begin
                old_next = map_rdata;
            end
            S_ASSIGN:
            begin
                if (old_reg == 10'd0)
                begin
                    map_we = 1'b1;
                    res_next.accepted = 1'b1;
                end
                else if (dens_rdata_a < dens_rdata_b)
                begin
                    // newcomer is denser: take the point, shrink the old holder
                    map_we     = 1'b1;
                    size_we    = 1'b1;
                    size_waddr = old_reg[OBJ_W-1:0];
                    size_wdata = (size_rdata_a != 13'd0) ? size_rdata_a - 13'd1 : 13'd0;
                    res_next.accepted = 1'b1;
                end
                else
                begin
                    size_we    = 1'b1;
                    size_waddr = item_reg.object_id[OBJ_W-1:0];
                    size_wdata = (size_rdata_b != 13'd0) ? size_rdata_b - 13'd1 : 13'd0;
                end
            end
            S_QPOINT:
            begin
                if (old_reg != 10'd0)
                begin
                    res_next.final_id     = fid_rdata;
                    res_next.category_out = cat_rdata;
                end
            end
            S_QCAT:
            begin
                res_next.cat_object_count = tcnt_rdata;
                res_next.cat_point_sum    = tsum_rdata;
            end
            S_FIN_RD:
            begin
                size_raddr_a = walk_reg[OBJ_W-1:0];
                cat_raddr    = walk_reg[OBJ_W-1:0];
                res_next.final_id = next_id_reg;
            end
            S_FIN_TL:
            begin
                fid_we      = 1'b1;
                fid_waddr   = walk_reg[OBJ_W-1:0];
                tally_raddr = cat_rdata[CAT_W-1:0];
                fsize_next  = size_rdata_a;
                old_next    = 10'(cat_rdata);
                if (size_rdata_a < min_reg)
                begin
                    walk_next = walk_reg + CNT_W'(1);
                end
                else
                begin
                    fid_wdata    = next_id_reg + 21'd1;
                    next_id_next = next_id_reg + 21'd1;
                end
            end
            S_FIN_WR:
            begin
                tally_we    = 1'b1;
                tally_waddr = old_reg[CAT_W-1:0];
                tcnt_wdata  = (tcnt_rdata < CNT_MAX) ? tcnt_rdata + 10'd1 : tcnt_rdata;
                tsum_wdata  = (sum_wide > {1'b0, SIZE_MAX}) ? SIZE_MAX : sum_wide[12:0];
                walk_next   = walk_reg + CNT_W'(1);
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            result_valid_reg <= 1'b0;
            start_reg        <= 20'd0;
            min_reg          <= 13'd1;
            obj_count_reg    <= CNT_W'(1);
            cur_cat_reg      <= 6'd1;
            clr_reg          <= '0;
            walk_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            obj_count_reg    <= obj_count_next;
            cur_cat_reg      <= cur_cat_next;
            clr_reg          <= clr_next;
            walk_reg         <= walk_next;
            if (cfg_write && cfg_index == REG_START)
            begin
                start_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_MIN)
            begin
                min_reg <= cfg_data[12:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (state_reg == S_RESP && out_free)
        begin
            result_reg <= res_reg;
        end
        res_reg     <= res_next;
        next_id_reg <= next_id_next;
        old_reg     <= old_next;
        fsize_reg   <= fsize_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (obj_count_reg != '0) && (obj_count_reg <= CNT_W'(OBJECTS)))
        else $error("object count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_cat_reg != 6'd0)
        else $error("current category fell to zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> result_valid)
        else $error("result lost at hand-over");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.accepted |-> result.status == ST_OK)
        else $error("accepted flag set on a failed assign");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import poat_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD      = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_data = '0;

    point_object_assignment_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted table state
    logic [9:0]  owner_of_point [POINTS];
    logic [12:0] obj_size [OBJECTS];
    logic [15:0] obj_density [OBJECTS];
    logic [5:0]  obj_category [OBJECTS];
    logic [20:0] obj_final_id [OBJECTS];
    int          obj_count;
    logic [5:0]  cur_category;
    logic [9:0]  cat_objects [CATEGORIES];
    logic [12:0] cat_points [CATEGORIES];
    logic [19:0] start_id;
    logic [12:0] min_size;

    result_t expected_results [$];
    int      errors = 0;
    bit      idle_on = 1'b1;
    int      hold_requests = 0;
    int      hold_seen = 0;
    int      hold_left = 0;
    int      burst_left = 0;
    int      quiet_cycles = 0;

    function automatic result_t table_step(item_t w);
        result_t r;
        logic [9:0] old;
        logic [20:0] next;
        logic [13:0] s;
        r = '0;
        case (w.command)
            CMD_ADD:
                if (obj_count >= OBJECTS)
                    r.status = ST_FULL;
                else
                begin
                    obj_size[obj_count]     = w.object_size;
                    obj_density[obj_count]  = w.object_cohesion;
                    obj_category[obj_count] = cur_category;
                    obj_final_id[obj_count] = '0;
                    r.new_object_id = obj_count[9:0];
                    obj_count++;
                end
            CMD_FINCAT:
                if (cur_category < CATEGORIES - 1)
                    cur_category++;
            CMD_ASSIGN:
                if (w.object_id == 0 || w.object_id >= obj_count)
                    r.status = ST_RANGE;
                else
                begin
                    old = owner_of_point[w.point_index];
                    if (old == 0)
                    begin
                        owner_of_point[w.point_index] = w.object_id;
                        r.accepted = 1'b1;
                    end
                    else if (obj_density[old] < obj_density[w.object_id])
                    begin
                        owner_of_point[w.point_index] = w.object_id;
                        if (obj_size[old] != 0)
                            obj_size[old]--;
                        r.accepted = 1'b1;
                    end
                    else if (obj_size[w.object_id] != 0)
                        obj_size[w.object_id]--;
                end
            CMD_FINAL:
            begin
                next = {1'b0, start_id};
                for (int k = 1; k < obj_count; k++)
                begin
                    if (obj_size[k] < min_size)
                        obj_final_id[k] = '0;
                    else
                    begin
                        next = next + 1'b1;
                        obj_final_id[k] = next;
                        if (cat_objects[obj_category[k]] != CNT_MAX)
                            cat_objects[obj_category[k]]++;
                        s = cat_points[obj_category[k]] + obj_size[k];
                        cat_points[obj_category[k]] = (s > SIZE_MAX) ? SIZE_MAX : s[12:0];
                    end
                end
                r.final_id = next;
            end
            CMD_QPOINT:
            begin
                old = owner_of_point[w.point_index];
                if (old != 0)
                begin
                    r.final_id     = obj_final_id[old];
                    r.category_out = obj_category[old];
                end
            end
            CMD_QCAT:
            begin
                r.cat_object_count = cat_objects[w.category_id];
                r.cat_point_sum    = cat_points[w.category_id];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(item_t w);
        result_t exp_w;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        exp_w = table_step(w);
        expected_results.insert(expected_results.size(), exp_w);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] data);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_START)
            start_id = data;
        else
            min_size = data[12:0];
    endtask

    function automatic item_t make_word(logic [2:0] cmd, logic [12:0] sz, logic [15:0] coh,
                                        logic [11:0] pt, logic [9:0] oid, logic [5:0] cat);
        item_t w;
        w.command         = cmd;
        w.object_size     = sz;
        w.object_cohesion = coh;
        w.point_index     = pt;
        w.object_id       = oid;
        w.category_id     = cat;
        return w;
    endfunction

    // mostly well-formed commands on a small point pool, with some noise
    function automatic item_t random_word(int add_weight);
        item_t w;
        int pick;
        w.command         = 3'($urandom);
        w.object_size     = 13'($urandom);
        w.object_cohesion = 16'($urandom);
        w.point_index     = 12'($urandom);
        w.object_id       = 10'($urandom);
        w.category_id     = 6'($urandom);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) != 0)
            w.object_size = 13'($urandom_range(0, 24));
        if ($urandom_range(0, 4) != 0)
            w.point_index = 12'($urandom_range(0, 63));
        if (obj_count > 1 && $urandom_range(0, 9) != 0)
            w.object_id = 10'($urandom_range(1, obj_count - 1));
        if (pick < add_weight)
            w.command = CMD_ADD;
        else if (pick < add_weight + 8)
            w.command = CMD_FINCAT;
        else if (pick < add_weight + 48)
            w.command = CMD_ASSIGN;
        else if (pick < add_weight + 50)
            w.command = CMD_FINAL;
        else if (pick < add_weight + 70)
            w.command = CMD_QPOINT;
        else if (pick < add_weight + 85)
            w.command = CMD_QCAT;
        else if ($urandom_range(0, 1) != 0)
            w.command = CMD_RES_B;
        else
            w.command = CMD_RES_A;
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_word(CMD_QPOINT, '0, '0, 12'd0, '0, '0));
        send_word(make_word(CMD_QPOINT, '1, '1, 12'd4095, '1, '1));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd0, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd1, '0));
        send_word(make_word(CMD_ADD, 13'd0, 16'd0, '0, '0, '0));
        send_word(make_word(CMD_ADD, 13'd8191, 16'd65535, '1, '1, '1));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd1, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd2, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd1, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd2, '0));
        send_word(make_word(CMD_FINCAT, '0, '0, '0, '0, '0));
        send_word(make_word(CMD_ADD, 13'd4096, 16'd65535, '0, '0, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd0, 10'd3, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd4095, 10'd3, '0));
        send_word(make_word(CMD_ASSIGN, '0, '0, 12'd5, 10'd1023, '0));
        send_word(make_word(CMD_FINAL, '0, '0, '0, '0, '0));
        send_word(make_word(CMD_QPOINT, '0, '0, 12'd0, '0, '0));
        send_word(make_word(CMD_QPOINT, '0, '0, 12'd4095, '0, '0));
        send_word(make_word(CMD_QCAT, '0, '0, '0, '0, 6'd1));
        send_word(make_word(CMD_QCAT, '0, '0, '0, '0, 6'd2));
        send_word(make_word(CMD_QCAT, '0, '0, '0, '0, 6'd63));
        send_word(make_word(CMD_RES_A, '1, '1, '1, '1, '1));
        send_word(make_word(CMD_RES_B, '1, '1, '1, '1, '1));
        send_word(make_word(CMD_FINAL, '0, '0, '0, '0, '0));
    endtask

    task automatic test_random(int count, int add_weight);
        repeat (count)
            send_word(random_word(add_weight));
    endtask

    // hold the result side off while words keep coming, so the input backs up
    task automatic test_backpressure();
        hold_requests++;
        repeat (20)
            send_word(random_word(10));
        drain();
    endtask

    task automatic test_table_full();
        while (obj_count < OBJECTS)
            send_word(make_word(CMD_ADD, 13'($urandom_range(0, 6)), 16'($urandom), '0, '0, '0));
        repeat (3)
            send_word(make_word(CMD_ADD, '1, '1, '0, '0, '0));
        send_word(make_word(CMD_FINAL, '0, '0, '0, '0, '0));
    endtask

    task automatic report(string field, int unsigned exp_v, int unsigned act_v);
        $display("%0t: %s expected %0d actual %0d", $realtime, field, exp_v, act_v);
        errors++;
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word expected none actual %h",
                         $realtime, result);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.new_object_id != exp_r.new_object_id)
                    report("new_object_id", exp_r.new_object_id, result.new_object_id);
                if (result.accepted != exp_r.accepted)
                    report("accepted", exp_r.accepted, result.accepted);
                if (result.final_id != exp_r.final_id)
                    report("final_id", exp_r.final_id, result.final_id);
                if (result.category_out != exp_r.category_out)
                    report("category_out", exp_r.category_out, result.category_out);
                if (result.cat_object_count != exp_r.cat_object_count)
                    report("cat_object_count", exp_r.cat_object_count, result.cat_object_count);
                if (result.cat_point_sum != exp_r.cat_point_sum)
                    report("cat_point_sum", exp_r.cat_point_sum, result.cat_point_sum);
                if (result.status != exp_r.status)
                    report("status", exp_r.status, result.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen    <= hold_requests;
            hold_left    <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left   <= burst_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            burst_left   <= $urandom_range(0, 14);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("point_object_assignment_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < POINTS; i++)
            owner_of_point[i] = '0;
        for (int i = 0; i < OBJECTS; i++)
        begin
            obj_size[i]     = '0;
            obj_density[i]  = '0;
            obj_category[i] = '0;
            obj_final_id[i] = '0;
        end
        for (int i = 0; i < CATEGORIES; i++)
        begin
            cat_objects[i] = '0;
            cat_points[i]  = '0;
        end
        obj_count    = 1;
        cur_category = 6'd1;
        start_id     = '0;
        min_size     = 13'd1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(REG_START, 20'hFFFFF);
        write_reg(REG_MIN, 20'd0);
        test_random(30, 15);
        test_backpressure();
        write_reg(REG_START, 20'($urandom));
        write_reg(REG_MIN, 20'd4096);
        test_random(20, 15);
        write_reg(REG_START, 20'd0);
        write_reg(REG_MIN, 20'd3);
        test_random(20, 20);
        drain();
        test_table_full();
        write_reg(REG_MIN, 20'd1);
        idle_on = 1'b0;
        test_random(20, 10);
        drain();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("point_object_assignment_table: match");
        else
            $display("point_object_assignment_table: mismatch");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/poat_pkg.sv
hw/rtl/point_object_assignment_table.sv
bench/tb.sv
